FILE: hdl/vrp_pkg.sv
// shared types, constants and elaboration-time trig helpers for the vertex rotate/project block
// no dependencies; imported by every module under hdl
package vrp_pkg;

  localparam int IN_W     = 12;  // vertex coordinate width at the ports
  localparam int ANG_W    = 9;   // angle index width at the ports
  localparam int CW       = 14;  // internal coordinate width, covers the rotated norm
  localparam int SCREEN_W = 12;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX   = 12'hFFF;
  localparam logic [SCREEN_W-1:0] CANVAS_RESET = 12'd2048;

  // greedy subtract steps for the angle wrap, enough for the smallest table of 16 steps
  localparam int MOD_STEPS = 5;

  localparam logic [63:0] PI_Q48       = 64'h3243F6A8885A3;
  localparam logic [63:0] ONE_Q32      = 64'h100000000;
  localparam int          TAYLOR_TERMS = 8;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [ANG_W-1:0]     ax;
    logic [ANG_W-1:0]     ay;
    logic [ANG_W-1:0]     az;
  } vertex_t;

  // sin or cos of x (q32, 0..pi/4) by taylor series, used only to build the rom
  function automatic logic [63:0] taylor_q32(input logic [63:0] x, input logic want_cos);
    logic [63:0] ts;
    logic [63:0] ss;
    logic [63:0] tc;
    logic [63:0] sc;
    ts = x;
    ss = x;
    tc = ONE_Q32;
    sc = ONE_Q32;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      ts = (ts * x) >> 32;
      ts = (ts * x) >> 32;
      ts = ts / 64'((2 * k) * (2 * k + 1));
      tc = (tc * x) >> 32;
      tc = (tc * x) >> 32;
      tc = tc / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        ss = ss - ts;
        sc = sc - tc;
      end else begin
        ss = ss + ts;
        sc = sc + tc;
      end
    end
    return want_cos ? sc : ss;
  endfunction

  // q32 magnitude to q(frac), round half up
  function automatic logic [63:0] round_q32(input logic [63:0] mag, input int frac);
    return (mag + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

endpackage

FILE: hdl/vrp_rotate_cell.sv
// one rotation cell: wraps its angle, looks up sin/cos, rotates one coordinate pair
// depends on vrp_pkg; five registered stages, each with its own valid
module vrp_rotate_cell
  import vrp_pkg::*;
#(
  parameter axis_t AXIS           = AXIS_X,
  parameter int    ANGLE_STEPS    = 360,
  parameter int    TRIG_FRAC_BITS = 14
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  vertex_t in_vtx,
  output logic    out_valid,
  input  logic    out_ready,
  output vertex_t out_vtx
);

  localparam int AW   = $clog2(ANGLE_STEPS);
  localparam int QW   = AW + 2;
  localparam int HALF = ANGLE_STEPS / 2;
  localparam int MW   = $clog2(HALF + 1);
  localparam int MAGW = TRIG_FRAC_BITS + 1;
  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int PW   = CW + TW;
  localparam int SW   = PW + 1;

  localparam logic signed [TW-1:0] TRIG_ONE = TW'(64'd1 << TRIG_FRAC_BITS);

  // eighth-wave rom (0..pi/4), indexed by the folded angle
  logic [MAGW-1:0] sin_rom [HALF+1];
  logic [MAGW-1:0] cos_rom [HALF+1];

  for (genvar gm = 0; gm <= HALF; gm++) begin : g_rom
    localparam logic [63:0] ANG =
      ((PI_Q48 * 64'(gm)) / 64'(2 * ANGLE_STEPS) + 64'd32768) >> 16;
    assign sin_rom[gm] = MAGW'(round_q32(taylor_q32(ANG, 1'b0), TRIG_FRAC_BITS));
    assign cos_rom[gm] = MAGW'(round_q32(taylor_q32(ANG, 1'b1), TRIG_FRAC_BITS));
  end

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  vertex_t vtx1, vtx2, vtx3, vtx4, vtx5;
  logic [AW-1:0] idx1;
  logic [MW-1:0] m2;
  quad_t         q2;
  logic          comp2;
  logic signed [TW-1:0] sin3, cos3;
  logic signed [PW-1:0] p_ac, p_bs, p_as, p_bc;

  logic [ANG_W-1:0] ang_in;
  logic [ANG_W-1:0] red_v;
  logic [AW-1:0]    idx_next;
  logic [QW-1:0]    quad_v;
  logic [1:0]       q_bits;
  logic             comp_next;
  logic [QW-1:0]    m_full;
  logic [MW-1:0]    m_next;
  logic [MAGW-1:0]  mag_sa, mag_ca;
  logic signed [TW-1:0] pos_sa, pos_ca;
  logic signed [TW-1:0] sin_next, cos_next;
  logic signed [CW-1:0] a3, b3;
  logic signed [SW-1:0] ra, rb;
  logic signed [CW-1:0] na, nb;
  vertex_t vtx5_next;

  // a slot moves when it is empty or its neighbor takes its beat
  assign rdy5     = ~v5 | out_ready;
  assign rdy4     = ~v4 | rdy5;
  assign rdy3     = ~v3 | rdy4;
  assign rdy2     = ~v2 | rdy3;
  assign rdy1     = ~v1 | rdy2;
  assign in_ready = rdy1;

  assign out_valid = v5;
  assign out_vtx   = vtx5;

  // stage 1: wrap the angle into 0..ANGLE_STEPS-1
  always_comb begin
    unique case (AXIS)
      AXIS_X:  ang_in = in_vtx.ax;
      AXIS_Y:  ang_in = in_vtx.ay;
      AXIS_Z:  ang_in = in_vtx.az;
      default: ang_in = in_vtx.ax;
    endcase
    red_v = ang_in;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(red_v) >= (32'(ANGLE_STEPS) << k)) begin
        red_v = red_v - ANG_W'(32'(ANGLE_STEPS) << k);
      end
    end
    idx_next = AW'(red_v);
  end

  // stage 2: quadrant, fold into the first eighth
  always_comb begin
    quad_v = {idx1, 2'b00};
    q_bits = 2'b00;
    if (quad_v >= QW'(2 * ANGLE_STEPS)) begin
      q_bits[1] = 1'b1;
      quad_v    = quad_v - QW'(2 * ANGLE_STEPS);
    end
    if (quad_v >= QW'(ANGLE_STEPS)) begin
      q_bits[0] = 1'b1;
      quad_v    = quad_v - QW'(ANGLE_STEPS);
    end
    comp_next = (quad_v << 1) > QW'(ANGLE_STEPS);
    m_full    = comp_next ? (QW'(ANGLE_STEPS) - quad_v) : quad_v;
    m_next    = MW'(m_full);
  end

  // stage 3: rom read, swap past the eighth, signs by quadrant
  always_comb begin
    mag_sa = comp2 ? cos_rom[m2] : sin_rom[m2];
    mag_ca = comp2 ? sin_rom[m2] : cos_rom[m2];
    pos_sa = $signed({1'b0, mag_sa});
    pos_ca = $signed({1'b0, mag_ca});
    unique case (q2)
      QUAD_0: begin
        sin_next = pos_sa;
        cos_next = pos_ca;
      end
      QUAD_1: begin
        sin_next = pos_ca;
        cos_next = -pos_sa;
      end
      QUAD_2: begin
        sin_next = -pos_sa;
        cos_next = -pos_ca;
      end
      QUAD_3: begin
        sin_next = -pos_ca;
        cos_next = pos_sa;
      end
    endcase
  end

  // pair (a, b) rotated as a' = a*c - b*s, b' = a*s + b*c
  always_comb begin
    unique case (AXIS)
      AXIS_X: begin
        a3 = vtx3.y;
        b3 = vtx3.z;
      end
      AXIS_Y: begin
        a3 = vtx3.z;
        b3 = vtx3.x;
      end
      AXIS_Z: begin
        a3 = vtx3.x;
        b3 = vtx3.y;
      end
      default: begin
        a3 = vtx3.y;
        b3 = vtx3.z;
      end
    endcase
  end

  // stage 5: sums, floor shift out of q format
  always_comb begin
    ra        = SW'(p_ac) - SW'(p_bs);
    rb        = SW'(p_as) + SW'(p_bc);
    na        = CW'(ra >>> TRIG_FRAC_BITS);
    nb        = CW'(rb >>> TRIG_FRAC_BITS);
    vtx5_next = vtx4;
    unique case (AXIS)
      AXIS_X: begin
        vtx5_next.y = na;
        vtx5_next.z = nb;
      end
      AXIS_Y: begin
        vtx5_next.z = na;
        vtx5_next.x = nb;
      end
      AXIS_Z: begin
        vtx5_next.x = na;
        vtx5_next.y = nb;
      end
      default: begin
        vtx5_next.y = na;
        vtx5_next.z = nb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      vtx1 <= in_vtx;
      idx1 <= idx_next;
    end
    if (rdy2 && v1) begin
      vtx2  <= vtx1;
      m2    <= m_next;
      q2    <= quad_t'(q_bits);
      comp2 <= comp_next;
    end
    if (rdy3 && v2) begin
      vtx3 <= vtx2;
      sin3 <= sin_next;
      cos3 <= cos_next;
    end
    if (rdy4 && v3) begin
      vtx4 <= vtx3;
      p_ac <= a3 * cos3;
      p_bs <= b3 * sin3;
      p_as <= a3 * sin3;
      p_bc <= b3 * cos3;
    end
    if (rdy5 && v4) begin
      vtx5 <= vtx5_next;
    end
  end

  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted beat did not reach the first stage");

  a_index_wrapped : assert property (@(posedge clk) disable iff (rst)
    v1 |-> (int'(idx1) < ANGLE_STEPS))
    else $error("wrapped angle index out of range");

  a_trig_bound : assert property (@(posedge clk) disable iff (rst)
    v3 |-> (sin3 <= TRIG_ONE) && (sin3 >= -TRIG_ONE) &&
           (cos3 <= TRIG_ONE) && (cos3 >= -TRIG_ONE))
    else $error("sin/cos beyond unit magnitude");

endmodule

FILE: hdl/vrp_project_cell.sv
// projection cell: drops z, adds the canvas offset, saturates to the screen and flags clipping
// depends on vrp_pkg; its result register is the block's output register
module vrp_project_cell
  import vrp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vertex_t             in_vtx,
  input  logic [SCREEN_W-1:0] center_ofs,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SCREEN_W-1:0] px,
  output logic [SCREEN_W-1:0] py,
  output logic                clipped
);

  localparam int SUMW = CW + 1;

  logic signed [SUMW-1:0] ofs_s, sx, sy;
  logic [SCREEN_W-1:0]    px_next, py_next;
  logic                   clip_x, clip_y;

  assign in_ready = ~out_valid | out_ready;

  always_comb begin
    ofs_s = $signed(SUMW'(center_ofs));
    sx    = SUMW'(in_vtx.x) + ofs_s;
    sy    = SUMW'(in_vtx.y) + ofs_s;
    clip_x = 1'b1;
    clip_y = 1'b1;
    priority if (sx < 0) begin
      px_next = '0;
    end else if (sx > $signed(SUMW'(SCREEN_MAX))) begin
      px_next = SCREEN_MAX;
    end else begin
      px_next = SCREEN_W'(sx);
      clip_x  = 1'b0;
    end
    priority if (sy < 0) begin
      py_next = '0;
    end else if (sy > $signed(SUMW'(SCREEN_MAX))) begin
      py_next = SCREEN_MAX;
    end else begin
      py_next = SCREEN_W'(sy);
      clip_y  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      px      <= px_next;
      py      <= py_next;
      clipped <= clip_x | clip_y;
    end
  end

  a_clip_at_edge : assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (px == '0) || (px == SCREEN_MAX) || (py == '0) || (py == SCREEN_MAX))
    else $error("clip flag set with both coordinates inside the screen");

endmodule

FILE: hdl/vertex_rotate_project_top.sv
// top level: three rotation cells (x, then y, then z) chained into the projection cell
// depends on vrp_pkg, vrp_rotate_cell, vrp_project_cell
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+------------------------------
//  in       | in_valid/in_ready, vx vy vz ang_x..ang_z  | one vertex and three angles
//  out      | out_valid/out_ready, px py clipped        | one projected screen point
//  cfg      | cfg_wr_en, cfg_wr_data                    | canvas offset, taken at once
//
// one vertex per cycle while out_ready holds; an accepted beat passes five stages per
// rotation cell, the product/sum pair of each set by one multiply stage and one add stage,
// plus the output register.
// reset clears the stage valids and loads canvas offset 2048; no clearing pass.
// each stage moves whenever it is empty or its neighbor takes its beat, so bubbles close
// up; in_ready falls only once all 16 slots hold a beat behind a waiting result.
module vertex_rotate_project_top
  import vrp_pkg::*;
#(
  parameter int ANGLE_STEPS    = 360,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  vx,
  input  logic signed [IN_W-1:0]  vy,
  input  logic signed [IN_W-1:0]  vz,
  input  logic [ANG_W-1:0]        ang_x,
  input  logic [ANG_W-1:0]        ang_y,
  input  logic [ANG_W-1:0]        ang_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SCREEN_W-1:0]     px,
  output logic [SCREEN_W-1:0]     py,
  output logic                    clipped,
  input  logic                    cfg_wr_en,
  input  logic [SCREEN_W-1:0]     cfg_wr_data
);

  logic [SCREEN_W-1:0] center_ofs;

  vertex_t vtx_in, vtx_rx, vtx_ry, vtx_rz;
  logic    rx_valid, rx_ready, ry_valid, ry_ready, rz_valid, rz_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_ofs <= CANVAS_RESET;
    end else if (cfg_wr_en) begin
      center_ofs <= cfg_wr_data;
    end
  end

  always_comb begin
    vtx_in.x  = CW'(vx);
    vtx_in.y  = CW'(vy);
    vtx_in.z  = CW'(vz);
    vtx_in.ax = ang_x;
    vtx_in.ay = ang_y;
    vtx_in.az = ang_z;
  end

  vrp_rotate_cell #(
    .AXIS           (AXIS_X),
    .ANGLE_STEPS    (ANGLE_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_vtx    (vtx_in),
    .out_valid (rx_valid),
    .out_ready (rx_ready),
    .out_vtx   (vtx_rx)
  );

  vrp_rotate_cell #(
    .AXIS           (AXIS_Y),
    .ANGLE_STEPS    (ANGLE_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx_valid),
    .in_ready  (rx_ready),
    .in_vtx    (vtx_rx),
    .out_valid (ry_valid),
    .out_ready (ry_ready),
    .out_vtx   (vtx_ry)
  );

  vrp_rotate_cell #(
    .AXIS           (AXIS_Z),
    .ANGLE_STEPS    (ANGLE_STEPS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ry_valid),
    .in_ready  (ry_ready),
    .in_vtx    (vtx_ry),
    .out_valid (rz_valid),
    .out_ready (rz_ready),
    .out_vtx   (vtx_rz)
  );

  vrp_project_cell u_project (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rz_valid),
    .in_ready   (rz_ready),
    .in_vtx     (vtx_rz),
    .center_ofs (center_ofs),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .px         (px),
    .py         (py),
    .clipped    (clipped)
  );

endmodule
